/* rtl/gsa_pkg.sv */
package gsa_pkg;

  // Request kinds carried on s_tuser
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status carried on m_tuser
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  // Fixed field widths of the stream payloads
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned HIDX_W    = 6;
  localparam int unsigned HGEN_W    = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  // Read and write strobes of one memory port pair
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

/* rtl/gsa_slot_table.sv */
module gsa_slot_table
  import gsa_pkg::*;
#(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned GEN_W = 16,
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk,
  input  mem_cmd_t         cmd,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_alive,
  output logic [GEN_W-1:0] rd_gen,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic             wr_alive,
  input  logic [GEN_W-1:0] wr_gen,
  input  logic [TAG_W-1:0] wr_owner
);

  // Entry word: alive flag above the generation
  logic [GEN_W:0]   slot_mem  [SLOTS];
  logic [TAG_W-1:0] owner_mem [SLOTS];
  logic [GEN_W:0]   rd_word;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      slot_mem[wr_addr]  <= {wr_alive, wr_gen};
      owner_mem[wr_addr] <= wr_owner;
    end
    if (cmd.rd) begin
      rd_word <= slot_mem[rd_addr];
    end
  end

  assign rd_alive = rd_word[GEN_W];
  assign rd_gen   = rd_word[GEN_W-1:0];

endmodule

/* rtl/gsa_free_stack.sv */
module gsa_free_stack
  import gsa_pkg::*;
#(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned GEN_W = 16,
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk,
  input  mem_cmd_t         cmd,
  input  logic [IDX_W-1:0] rd_ptr,
  output logic [IDX_W-1:0] rd_idx,
  output logic [GEN_W-1:0] rd_gen,
  input  logic [IDX_W-1:0] wr_ptr,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [GEN_W-1:0] wr_gen
);

  // Each entry keeps the freed index and the generation it died with
  logic [GEN_W+IDX_W-1:0] stack_mem [SLOTS];
  logic [GEN_W+IDX_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      stack_mem[wr_ptr] <= {wr_gen, wr_idx};
    end
    if (cmd.rd) begin
      rd_word <= stack_mem[rd_ptr];
    end
  end

  assign rd_idx = rd_word[IDX_W-1:0];
  assign rd_gen = rd_word[GEN_W+IDX_W-1:IDX_W];

endmodule

/* rtl/generational_slot_allocator_core.sv */
// Generational slot allocator.
// Input channel s_*: one item is a request. s_tuser selects allocate or free;
// s_tdata carries the owner tag for an allocate and the handle for a free.
// Output channel m_*: exactly one item per request, in request order, with
// the allocated index and generation in m_tdata and the status in m_tuser
// (done, table full, handle ignored).
// Timing: when a request is accepted, the slot table is read at the handle
// index and the free stack at its top. In the execute state the read data
// is checked; once the output register is free, the table is written on a
// done result, the stack on an honored free, and the result is loaded into
// the output register. Registered memory reads and the write-back keep the
// block from accepting a new request until the last one leaves S_EXEC.
// The output register holds a finished result while m_tready is low; the
// next request can be accepted meanwhile and then waits in its execute cycle
// (no memory write happens) until the output register frees up.
// Reset clears the counters and the control state only. Slots at or above
// the never-used mark count as dead, so no clearing pass is needed and the
// block takes requests as soon as reset is released.
module generational_slot_allocator_core
  import gsa_pkg::*;
#(
  parameter int unsigned SLOTS           = 64,
  parameter int unsigned GENERATION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] owner_tag, [16] handle_present, [22:17] handle_index,
  // [38:23] handle_generation, [39] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] operation
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [5:0] slot_index, [21:6] slot_generation, [23:22] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  // [1:0] status
  output logic [1:0]            m_tuser
);

  localparam int unsigned GEN_W  = GENERATION_BITS;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned HI_W   = (IDX_W > HIDX_W) ? IDX_W : HIDX_W;
  localparam int unsigned HG_W   = (GEN_W > HGEN_W) ? GEN_W : HGEN_W;

  state_t state, state_next;

  // Request register
  logic              req_op;
  logic [TAG_W-1:0]  req_tag;
  logic              req_present;
  logic [HIDX_W-1:0] req_hidx;
  logic [HGEN_W-1:0] req_hgen;

  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] used_slots;

  logic accept, advance;

  mem_cmd_t         tbl_cmd, stk_cmd;
  logic [HI_W-1:0]  in_hidx_ext, req_hidx_ext;
  logic [IDX_W-1:0] tbl_rd_addr, req_addr;
  logic             tbl_alive;
  logic [GEN_W-1:0] tbl_gen;
  logic [IDX_W-1:0] tbl_wr_addr;
  logic             tbl_wr_alive;
  logic [GEN_W-1:0] tbl_wr_gen;
  logic [TAG_W-1:0] tbl_wr_owner;
  logic [IDX_W-1:0] stk_rd_ptr;
  logic [IDX_W-1:0] stk_idx;
  logic [GEN_W-1:0] stk_gen;

  logic [HG_W-1:0]  hgen_ext;
  logic [GEN_W-1:0] hgen_cmp;

  logic             is_alloc, from_stack, take_new, alloc_ok, free_ok;
  logic [IDX_W-1:0] alloc_idx;
  logic [GEN_W-1:0] alloc_gen;
  logic [HI_W-1:0]  out_idx_ext;
  logic [HG_W-1:0]  out_gen_ext;
  logic [1:0]       res_status;
  logic [HIDX_W-1:0] res_idx;
  logic [HGEN_W-1:0] res_gen;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign advance  = (state == S_EXEC) && (!m_tvalid || m_tready);

  // Read addresses: the table index comes straight from the incoming item, the stack pointer from the free count
  assign in_hidx_ext = HI_W'(s_tdata[22:17]);
  assign tbl_rd_addr = in_hidx_ext[IDX_W-1:0];
  assign stk_rd_ptr  = IDX_W'(free_count - CNT_W'(1));

  assign req_hidx_ext = HI_W'(req_hidx);
  assign req_addr     = req_hidx_ext[IDX_W-1:0];
  assign hgen_ext     = HG_W'(req_hgen);
  assign hgen_cmp     = hgen_ext[GEN_W-1:0];

  gsa_slot_table #(
    .SLOTS (SLOTS),
    .GEN_W (GEN_W),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .cmd      (tbl_cmd),
    .rd_addr  (tbl_rd_addr),
    .rd_alive (tbl_alive),
    .rd_gen   (tbl_gen),
    .wr_addr  (tbl_wr_addr),
    .wr_alive (tbl_wr_alive),
    .wr_gen   (tbl_wr_gen),
    .wr_owner (tbl_wr_owner)
  );

  gsa_free_stack #(
    .SLOTS (SLOTS),
    .GEN_W (GEN_W),
    .IDX_W (IDX_W)
  ) u_stack (
    .clk    (clk),
    .cmd    (stk_cmd),
    .rd_ptr (stk_rd_ptr),
    .rd_idx (stk_idx),
    .rd_gen (stk_gen),
    .wr_ptr (free_count[IDX_W-1:0]),
    .wr_idx (req_addr),
    .wr_gen (tbl_gen)
  );

  always_comb begin
    is_alloc   = (req_op == OP_ALLOC);
    from_stack = (free_count != '0);
    take_new   = !from_stack && (used_slots < CNT_W'(SLOTS));
    alloc_ok   = from_stack || take_new;
    // A slot at or above the never-used mark has never been written: dead
    free_ok    = req_present
                 && (32'(req_hidx) < 32'(used_slots))
                 && tbl_alive
                 && (tbl_gen == hgen_cmp)
                 && (free_count < CNT_W'(SLOTS));

    // Reuse the most recently freed slot, generation bumped; else the next never-used slot, generation zero
    alloc_idx = from_stack ? stk_idx : used_slots[IDX_W-1:0];
    alloc_gen = from_stack ? (stk_gen + GEN_W'(1)) : '0;

    tbl_cmd.rd   = accept;
    tbl_cmd.wr   = advance && (is_alloc ? alloc_ok : free_ok);
    tbl_wr_addr  = is_alloc ? alloc_idx : req_addr;
    tbl_wr_alive = is_alloc;
    tbl_wr_gen   = is_alloc ? alloc_gen : tbl_gen;
    tbl_wr_owner = is_alloc ? req_tag : '0;

    stk_cmd.rd = accept;
    stk_cmd.wr = advance && !is_alloc && free_ok;

    out_idx_ext = '0;
    out_gen_ext = '0;
    if (is_alloc) begin
      if (alloc_ok) begin
        res_status  = STAT_DONE;
        out_idx_ext = HI_W'(alloc_idx);
        out_gen_ext = HG_W'(alloc_gen);
      end else begin
        res_status = STAT_FULL;
      end
    end else begin
      res_status = free_ok ? STAT_DONE : STAT_IGNORED;
    end
    res_idx = out_idx_ext[HIDX_W-1:0];
    res_gen = out_gen_ext[HGEN_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (advance) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      used_slots <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        m_tvalid <= 1'b1;
        // Pop, take a fresh slot, or push
        if (is_alloc) begin
          if (from_stack) begin
            free_count <= free_count - CNT_W'(1);
          end else if (take_new) begin
            used_slots <= used_slots + CNT_W'(1);
          end
        end else if (free_ok) begin
          free_count <= free_count + CNT_W'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers: hold request while in execute, hold result until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op      <= s_tuser;
      req_tag     <= s_tdata[15:0];
      req_present <= s_tdata[16];
      req_hidx    <= s_tdata[22:17];
      req_hgen    <= s_tdata[38:23];
    end
    if (advance) begin
      m_tdata <= {2'b00, res_gen, res_idx};
      m_tuser <= res_status;
    end
  end

  // Every index on the free stack belongs to a slot that was handed out
  a_free_le_used: assert property (@(posedge clk) disable iff (rst)
    free_count <= used_slots)
    else $error("free stack deeper than the number of used slots");

  a_used_le_slots: assert property (@(posedge clk) disable iff (rst)
    used_slots <= CNT_W'(SLOTS))
    else $error("never-used mark ran past the table");

  // A push happens only for an honored free, which reports done and no slot
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    stk_cmd.wr |=> m_tvalid && (m_tuser == STAT_DONE) && (m_tdata == '0))
    else $error("free pushed an index without a done result");

  // A reported full table leaves the counters untouched
  a_full_steady: assert property (@(posedge clk) disable iff (rst)
    (advance && is_alloc && !alloc_ok) |=>
      $stable(free_count) && $stable(used_slots))
    else $error("full allocate changed the counters");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import gsa_pkg::*;

  localparam int SLOT_COUNT  = 64;
  localparam int CYCLE_LIMIT = 2_000_000;

  // One request as it travels on s_tdata / s_tuser
  typedef struct packed {
    logic                op;
    logic [TAG_W-1:0]    tag;
    logic                present;
    logic [HIDX_W-1:0]   hidx;
    logic [HGEN_W-1:0]   hgen;
  } request_t;

  // One result as it travels on m_tdata / m_tuser
  typedef struct packed {
    logic [HIDX_W-1:0]   idx;
    logic [HGEN_W-1:0]   gen;
    logic [1:0]          status;
  } slot_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;

  // Shadow of the slot map, advanced at each accepted request
  logic [HGEN_W-1:0] gen_of [SLOT_COUNT];
  bit                alive_of [SLOT_COUNT];
  logic [HIDX_W-1:0] free_lifo [SLOT_COUNT];
  int                free_depth;
  int                used_count;

  slot_result_t pending_results[$];
  int           results_owed;
  int           mismatches;
  int           cycle_count;
  int           sender_idle_pct;
  int           receiver_idle_pct;
  int           stall_left;

  generational_slot_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** generational_slot_allocator_core: FAILED **");
      $finish;
    end
  end

  // Receiver: a requested long hold-off wins over the random stall pattern
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Advance the shadow slot map by one request and return the result it owes.
  // Allocate pops the most recently freed index (generation bumped), else
  // takes the next never-used index at generation zero, else reports full.
  // Free is honored only for a present handle on a live slot whose
  // generation matches; the index is then pushed for reuse.
  function automatic slot_result_t apply_request(request_t r);
    slot_result_t res;
    logic [HIDX_W-1:0] idx;
    res = '0;
    if (r.op == OP_ALLOC) begin
      if (free_depth > 0) begin
        free_depth--;
        idx = free_lifo[free_depth];
        gen_of[idx] = gen_of[idx] + HGEN_W'(1);
      end else if (used_count < SLOT_COUNT) begin
        idx = HIDX_W'(used_count);
        used_count++;
        gen_of[idx] = '0;
      end else begin
        res.status = STAT_FULL;
        return res;
      end
      alive_of[idx] = 1'b1;
      res.idx       = idx;
      res.gen       = gen_of[idx];
      res.status    = STAT_DONE;
    end else if (!r.present || !alive_of[r.hidx] || gen_of[r.hidx] != r.hgen ||
                 free_depth >= SLOT_COUNT) begin
      res.status = STAT_IGNORED;
    end else begin
      alive_of[r.hidx]      = 1'b0;
      free_lifo[free_depth] = r.hidx;
      free_depth++;
      res.status = STAT_DONE;
    end
    return res;
  endfunction

  // Check each delivered result against the oldest owed one, then log the
  // request accepted on the same edge (its result cannot appear that early)
  always @(posedge clk) begin
    request_t     seen;
    slot_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: m_tdata=%h m_tuser=%h",
                 m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_owed--;
          if (m_tdata[5:0] !== want.idx) begin
            $error("slot_index: expected %0d, got %0d", want.idx, m_tdata[5:0]);
            mismatches++;
          end
          if (m_tdata[21:6] !== want.gen) begin
            $error("slot_generation: expected %0d, got %0d", want.gen, m_tdata[21:6]);
            mismatches++;
          end
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        seen.op      = s_tuser;
        seen.tag     = s_tdata[15:0];
        seen.present = s_tdata[16];
        seen.hidx    = s_tdata[22:17];
        seen.hgen    = s_tdata[38:23];
        pending_results.insert(pending_results.size(), apply_request(seen));
        results_owed++;
      end
    end
  end

  // Offer one item; enter and leave at a falling edge
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= {1'b0, r.hgen, r.hidx, r.present, r.tag};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_alloc(input logic [TAG_W-1:0] tag);
    request_t r;
    r      = request_t'(IN_DATA_W'({$urandom, $urandom}));
    r.op   = OP_ALLOC;
    r.tag  = tag;
    send_request(r);
  endtask

  task automatic send_free(input logic present, input logic [HIDX_W-1:0] hidx,
                           input logic [HGEN_W-1:0] hgen);
    request_t r;
    r         = '0;
    r.op      = OP_FREE;
    r.tag     = TAG_W'($urandom);
    r.present = present;
    r.hidx    = hidx;
    r.hgen    = hgen;
    send_request(r);
  endtask

  // Hold the sender until every owed result has been delivered
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    wait (results_owed == 0);
    @(negedge clk);
  endtask

  // Mostly well-formed traffic: live handles drawn from the shadow map, with
  // some absent, stale, double and fully random frees mixed in
  function automatic request_t random_request(int alloc_pct);
    request_t r;
    int       live[$];
    int       pick;
    r         = request_t'(IN_DATA_W'({$urandom, $urandom}));
    r.present = 1'b1;
    if ($urandom_range(99) < alloc_pct) begin
      r.op = OP_ALLOC;
      return r;
    end
    r.op = OP_FREE;
    for (int i = 0; i < SLOT_COUNT; i++)
      if (alive_of[i]) live.insert(live.size(), i);
    pick = $urandom_range(99);
    if (live.size() > 0 && pick < 75) begin
      r.hidx = HIDX_W'(live[$urandom_range(live.size() - 1)]);
      r.hgen = gen_of[r.hidx];
      if (pick < 6)
        r.present = 1'b0;
      else if (pick < 12)
        r.hgen = r.hgen ^ HGEN_W'($urandom_range(65535, 1));
    end else if (pick < 90) begin
      // random slot at its current generation: live, dead or never used
      r.hgen = gen_of[r.hidx];
    end else if (pick < 95) begin
      r.present = 1'b0;
    end
    return r;
  endfunction

  // Fresh allocations, reuse order and every reason a free is ignored
  task automatic test_free_rules();
    send_alloc(16'h0000);              // index 0, generation 0
    send_alloc(16'hFFFF);              // index 1, generation 0
    send_free(1'b0, 6'd0, 16'd0);      // no handle held
    send_free(1'b1, 6'd5, 16'd0);      // never-used slot
    send_free(1'b1, 6'd0, 16'd1);      // generation mismatch
    send_free(1'b1, 6'd0, 16'd0);      // done
    send_free(1'b1, 6'd0, 16'd0);      // double free
    send_alloc(16'hA5A5);              // reuse index 0 at generation 1
    send_free(1'b1, 6'd1, 16'h8000);   // top generation bit wrong
    send_free(1'b1, 6'd1, 16'd0);
    send_free(1'b1, 6'd0, 16'd1);
    send_alloc(16'h5A5A);              // last freed first: index 0, generation 2
    send_alloc(16'h1234);              // then index 1, generation 1
    send_free(1'b0, 6'd63, 16'hFFFF);
  endtask

  // Run out of slots, then report full
  task automatic test_slot_exhaustion();
    repeat (SLOT_COUNT + 1) send_alloc(TAG_W'($urandom));
    send_free(1'b1, 6'd63, 16'hFFFF);  // live but stale
    send_alloc(16'hFFFF);              // still full
  endtask

  // Cycle one slot through a run of generations
  task automatic test_generation_wrap();
    send_free(1'b1, 6'd63, gen_of[63]);
    repeat (20) begin
      send_alloc(TAG_W'($urandom));
      send_free(1'b1, 6'd63, gen_of[63]);
    end
  endtask

  task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    for (int i = 0; i < count; i++)
      send_request(random_request(((i / 96) % 2) ? 25 : 80));
  endtask

  // Stall the output long enough to back up the input, then drain fully
  task automatic test_backpressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    stall_left        = 400;
    repeat (24) send_request(random_request(50));
    wait_all_results();
    repeat (16) send_request(random_request(50));
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      gen_of[i]    = '0;
      alive_of[i]  = 1'b0;
      free_lifo[i] = '0;
    end
    free_depth        = 0;
    used_count        = 0;
    results_owed      = 0;
    mismatches        = 0;
    cycle_count       = 0;
    stall_left        = 0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    sender_idle_pct   = 16;
    receiver_idle_pct = 70;
    test_free_rules();
    test_slot_exhaustion();
    wait_all_results();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_generation_wrap();

    test_random_traffic(380, 16, 70);
    test_random_traffic(380, 70, 16);
    test_random_traffic(380, 0, 0);
    test_backpressure();

    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** generational_slot_allocator_core: PASSED **");
    end else begin
      $display("** generational_slot_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gsa_pkg.sv
rtl/gsa_slot_table.sv
rtl/gsa_free_stack.sv
rtl/generational_slot_allocator_core.sv
test/testbench.sv
